[design/tfn_pkg.sv]
// Shared types and constants for the triangle face normal unit.
// Holds the port item structs, the front-to-back item and the datapath widths.
// No dependencies.
package tfn_pkg;

  localparam int VERTEX_DEPTH_DEF = 1024;
  localparam int COORD_WIDTH_DEF  = 32;

  localparam int INDEX_W    = 10;
  localparam int COORD_IN_W = 32;
  localparam int NORMAL_W   = 16;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  // Datapath widths, sized for the widest coordinate
  localparam int EDGE_W     = COORD_IN_W + 1;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int MAG_W      = PROD_W + 1;
  localparam int SPLIT_W    = (MAG_W + 1) / 2;
  localparam int HI_W       = MAG_W - SPLIT_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int FRAC_SHIFT = 28;
  localparam int NUM_W      = SQ_W + FRAC_SHIFT;
  localparam int NORM_BITS  = 15;
  localparam int Q_W        = NORM_BITS;
  localparam int ACC_W      = NUM_W;
  localparam int QS_W       = SUM_W + Q_W;
  localparam int CAND_W     = NUM_W + 6;

  typedef enum logic {
    REQ_LOAD     = 1'b0,
    REQ_TRIANGLE = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic                         req_type;
    logic [INDEX_W-1:0]           vertex_index;
    logic signed [COORD_IN_W-1:0] coord_x;
    logic signed [COORD_IN_W-1:0] coord_y;
    logic signed [COORD_IN_W-1:0] coord_z;
    logic [INDEX_W-1:0]           corner_a;
    logic [INDEX_W-1:0]           corner_b;
    logic [INDEX_W-1:0]           corner_c;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]         out_corner_a;
    logic [INDEX_W-1:0]         out_corner_b;
    logic [INDEX_W-1:0]         out_corner_c;
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic                       degenerate;
  } out_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] a;
    logic [INDEX_W-1:0] b;
    logic [INDEX_W-1:0] c;
  } corners_t;

  // Edge vectors B-A and C-A, index 0 = x, 1 = y, 2 = z, two's complement
  typedef struct packed {
    corners_t              corners;
    logic [2:0][EDGE_W-1:0] e1;
    logic [2:0][EDGE_W-1:0] e2;
  } edge_item_t;

endpackage

[design/tfn_front.sv]
// Front part: vertex store, item intake and the three corner reads.
// Pushes edge vectors into the front-to-back queue. Depends on tfn_pkg.
module tfn_front #(
  parameter int VERTEX_DEPTH = tfn_pkg::VERTEX_DEPTH_DEF,
  parameter int COORD_WIDTH  = tfn_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  tfn_pkg::in_item_t                request,
  output logic                             full,
  input  logic [tfn_pkg::QUEUE_LVL_W-1:0]  q_level,
  output logic                             q_push,
  output tfn_pkg::edge_item_t              q_item
);

  localparam int ADDR_W = $clog2(VERTEX_DEPTH);
  localparam int WORD_W = 3 * COORD_WIDTH;
  localparam int LVL_W  = tfn_pkg::QUEUE_LVL_W;
  localparam int EDGE_W = tfn_pkg::EDGE_W;

  typedef enum logic [1:0] {PH_IDLE, PH_RD_B, PH_RD_C} phase_t;
  typedef enum logic [1:0] {RD_NONE, RD_A, RD_B, RD_C} rd_tag_t;

  phase_t phase;
  rd_tag_t rd_tag, rd_tag_next;
  logic pending;
  tfn_pkg::corners_t corners;
  logic [2:0][EDGE_W-1:0] va, vb, vcur;

  logic [WORD_W-1:0] mem [VERTEX_DEPTH];
  logic [WORD_W-1:0] rd_word;
  logic rd_oob;

  logic accept, tri_acc, load_acc, we, in_range;
  logic [tfn_pkg::INDEX_W-1:0] addr_idx;
  logic [31:0] idx_wide;
  logic [ADDR_W-1:0] addr;
  logic [WORD_W-1:0] wdata;
  logic signed [COORD_WIDTH-1:0] rd_coord [3];

  assign full = (phase != PH_IDLE) ||
                ((LVL_W + 1)'(q_level) + (LVL_W + 1)'(pending) >=
                 (LVL_W + 1)'(tfn_pkg::QUEUE_DEPTH));
  assign accept   = push && !full;
  assign tri_acc  = accept && (request.req_type == tfn_pkg::REQ_TRIANGLE);
  assign load_acc = accept && (request.req_type == tfn_pkg::REQ_LOAD);

  always_comb begin
    unique case (phase)
      PH_RD_B: addr_idx = corners.b;
      PH_RD_C: addr_idx = corners.c;
      default: addr_idx = (request.req_type == tfn_pkg::REQ_TRIANGLE) ?
                          request.corner_a : request.vertex_index;
    endcase
  end

  assign idx_wide = 32'(addr_idx);
  assign in_range = idx_wide < 32'(VERTEX_DEPTH);
  assign addr     = idx_wide[ADDR_W-1:0];
  assign we       = load_acc && in_range;
  assign wdata    = {request.coord_z[COORD_WIDTH-1:0], request.coord_y[COORD_WIDTH-1:0],
                     request.coord_x[COORD_WIDTH-1:0]};

  always_comb begin
    if (tri_acc) rd_tag_next = RD_A;
    else if (phase == PH_RD_B) rd_tag_next = RD_B;
    else if (phase == PH_RD_C) rd_tag_next = RD_C;
    else rd_tag_next = RD_NONE;
  end

  // Unpack the registered read word; out-of-range corners read as the origin
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rd_coord[i] = rd_word[i*COORD_WIDTH +: COORD_WIDTH];
      vcur[i] = rd_oob ? '0 : EDGE_W'(rd_coord[i]);
    end
  end

  always_comb begin
    q_push = (rd_tag == RD_C);
    q_item.corners = corners;
    for (int i = 0; i < 3; i++) begin
      q_item.e1[i] = vb[i] - va[i];
      q_item.e2[i] = vcur[i] - va[i];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rd_word <= mem[addr];
    rd_oob  <= !in_range;
  end

  always_ff @(posedge clk) begin
    if (tri_acc) corners <= '{a: request.corner_a, b: request.corner_b, c: request.corner_c};
    if (rd_tag == RD_A) va <= vcur;
    if (rd_tag == RD_B) vb <= vcur;
    if (rst) begin
      phase   <= PH_IDLE;
      rd_tag  <= RD_NONE;
      pending <= 1'b0;
    end else begin
      rd_tag <= rd_tag_next;
      unique case (phase)
        PH_IDLE: if (tri_acc) phase <= PH_RD_B;
        PH_RD_B: phase <= PH_RD_C;
        PH_RD_C: phase <= PH_IDLE;
        default: phase <= PH_IDLE;
      endcase
      if (tri_acc) pending <= 1'b1;
      else if (q_push) pending <= 1'b0;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_level < LVL_W'(tfn_pkg::QUEUE_DEPTH)))
    else $error("edge item pushed into a full queue");

  a_busy_pending: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> pending)
    else $error("corner reads running without a pending triangle");

  a_read_order: assert property (@(posedge clk) disable iff (rst)
    tri_acc |=> (phase == PH_RD_B && rd_tag == RD_A))
    else $error("triangle did not start its corner reads");

  a_push_time: assert property (@(posedge clk) disable iff (rst)
    tri_acc |-> ##3 q_push)
    else $error("triangle edges not pushed three cycles after intake");

endmodule

[design/tfn_queue.sv]
// Short queue of edge items between the front and the back part.
// Depends on tfn_pkg.
module tfn_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  tfn_pkg::edge_item_t             wr_item,
  input  logic                            pop,
  output tfn_pkg::edge_item_t             rd_item,
  output logic                            empty,
  output logic [tfn_pkg::QUEUE_LVL_W-1:0] level
);

  localparam int DEPTH = tfn_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  tfn_pkg::edge_item_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  assign empty   = (level == '0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_item;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

endmodule

[design/tfn_cross.sv]
// Back part, first half: cross product of the edges and squared components.
// Five stages, all advancing together on adv. Depends on tfn_pkg.
module tfn_cross (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  tfn_pkg::edge_item_t             in_item,
  output logic                            out_valid,
  output tfn_pkg::corners_t               out_corners,
  output logic [2:0][tfn_pkg::SQ_W-1:0]   out_sq,
  output logic [2:0]                      out_neg
);

  localparam int PROD_W  = tfn_pkg::PROD_W;
  localparam int MAG_W   = tfn_pkg::MAG_W;
  localparam int SPLIT_W = tfn_pkg::SPLIT_W;
  localparam int HI_W    = tfn_pkg::HI_W;
  localparam int SQ_W    = tfn_pkg::SQ_W;

  logic [4:0] v;
  tfn_pkg::edge_item_t c0;
  tfn_pkg::corners_t c1_cor, c2_cor, c3_cor;
  logic signed [PROD_W-1:0] prod [6];
  logic signed [PROD_W-1:0] prod_next [6];
  logic signed [MAG_W-1:0] diff [3];
  logic [MAG_W-1:0] mag [3];
  logic [2:0] neg2, neg3;
  logic [2*HI_W-1:0] hh [3];
  logic [HI_W+SPLIT_W-1:0] hl [3];
  logic [2*SPLIT_W-1:0] ll [3];

  always_comb begin
    prod_next[0] = $signed(c0.e1[1]) * $signed(c0.e2[2]);
    prod_next[1] = $signed(c0.e1[2]) * $signed(c0.e2[1]);
    prod_next[2] = $signed(c0.e1[2]) * $signed(c0.e2[0]);
    prod_next[3] = $signed(c0.e1[0]) * $signed(c0.e2[2]);
    prod_next[4] = $signed(c0.e1[0]) * $signed(c0.e2[1]);
    prod_next[5] = $signed(c0.e1[1]) * $signed(c0.e2[0]);
    for (int i = 0; i < 3; i++) begin
      diff[i] = MAG_W'(prod[2*i]) - MAG_W'(prod[2*i+1]);
    end
  end

  assign out_valid = v[4];

  always_ff @(posedge clk) begin
    if (adv) begin
      c0 <= in_item;
      c1_cor <= c0.corners;
      c2_cor <= c1_cor;
      c3_cor <= c2_cor;
      out_corners <= c3_cor;
      for (int i = 0; i < 6; i++) prod[i] <= prod_next[i];
      for (int i = 0; i < 3; i++) begin
        neg2[i] <= diff[i][MAG_W-1];
        mag[i]  <= diff[i][MAG_W-1] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
        hh[i] <= mag[i][MAG_W-1:SPLIT_W] * mag[i][MAG_W-1:SPLIT_W];
        hl[i] <= mag[i][MAG_W-1:SPLIT_W] * mag[i][SPLIT_W-1:0];
        ll[i] <= mag[i][SPLIT_W-1:0] * mag[i][SPLIT_W-1:0];
        out_sq[i] <= (SQ_W'(hh[i]) << (2 * SPLIT_W)) + (SQ_W'(hl[i]) << (SPLIT_W + 1)) +
                     SQ_W'(ll[i]);
      end
      neg3 <= neg2;
      out_neg <= neg3;
    end
    if (rst) v <= '0;
    else if (adv) v <= {v[3:0], in_valid};
  end

endmodule

[design/tfn_norm.sv]
// Back part, second half: unit-length normalization, one result bit per stage.
// Ends in the result register. Depends on tfn_pkg.
module tfn_norm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  tfn_pkg::corners_t             in_corners,
  input  logic [2:0][tfn_pkg::SQ_W-1:0] in_sq,
  input  logic [2:0]                    in_neg,
  output logic                          out_valid,
  output tfn_pkg::out_item_t            result
);

  localparam int NB     = tfn_pkg::NORM_BITS;
  localparam int SUM_W  = tfn_pkg::SUM_W;
  localparam int NUM_W  = tfn_pkg::NUM_W;
  localparam int ACC_W  = tfn_pkg::ACC_W;
  localparam int QS_W   = tfn_pkg::QS_W;
  localparam int Q_W    = tfn_pkg::Q_W;
  localparam int CAND_W = tfn_pkg::CAND_W;
  localparam int NRM_W  = tfn_pkg::NORMAL_W;

  // Stage 0 holds the squared length; stage k has settled result bit NB-k
  logic [NB:0] stv;
  tfn_pkg::corners_t stc [NB+1];
  logic std [NB+1];
  logic [SUM_W-1:0] sts [NB+1];
  logic [NUM_W-1:0] stn [NB+1][3];
  logic [ACC_W-1:0] sta [NB+1][3];
  logic [QS_W-1:0]  stqs [NB+1][3];
  logic [Q_W-1:0]   stq [NB+1][3];
  logic             stneg [NB+1][3];

  logic [SUM_W-1:0] sum;
  logic [CAND_W-1:0] cand [1:NB][3];
  logic fit [1:NB][3];
  logic [NRM_W-1:0] mag_out [3];
  logic [NRM_W-1:0] nrm [3];

  assign sum = SUM_W'(in_sq[0]) + SUM_W'(in_sq[1]) + SUM_W'(in_sq[2]);

  // Trial: (q + 2^b)^2 S = q^2 S + 2^(b+1) qS + 2^(2b) S, kept against c^2 2^28
  always_comb begin
    for (int k = 1; k <= NB; k++) begin
      for (int l = 0; l < 3; l++) begin
        cand[k][l] = CAND_W'(sta[k-1][l]) + (CAND_W'(stqs[k-1][l]) << (NB - k + 1)) +
                     (CAND_W'(sts[k-1]) << (2 * (NB - k)));
        fit[k][l] = cand[k][l] <= CAND_W'(stn[k-1][l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag_out[l] = NRM_W'(stq[NB][l]);
      nrm[l] = std[NB] ? '0 : (stneg[NB][l] ? NRM_W'(-mag_out[l]) : mag_out[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stc[0] <= in_corners;
      std[0] <= (sum == '0);
      sts[0] <= sum;
      for (int l = 0; l < 3; l++) begin
        stn[0][l]   <= NUM_W'(in_sq[l]) << tfn_pkg::FRAC_SHIFT;
        sta[0][l]   <= '0;
        stqs[0][l]  <= '0;
        stq[0][l]   <= '0;
        stneg[0][l] <= in_neg[l];
      end
      for (int k = 1; k <= NB; k++) begin
        stc[k] <= stc[k-1];
        std[k] <= std[k-1];
        sts[k] <= sts[k-1];
        for (int l = 0; l < 3; l++) begin
          stn[k][l]   <= stn[k-1][l];
          stneg[k][l] <= stneg[k-1][l];
          if (fit[k][l]) begin
            stq[k][l]  <= stq[k-1][l] | (Q_W'(1) << (NB - k));
            sta[k][l]  <= ACC_W'(cand[k][l]);
            stqs[k][l] <= stqs[k-1][l] + (QS_W'(sts[k-1]) << (NB - k));
          end else begin
            stq[k][l]  <= stq[k-1][l];
            sta[k][l]  <= sta[k-1][l];
            stqs[k][l] <= stqs[k-1][l];
          end
        end
      end
      result.out_corner_a <= stc[NB].a;
      result.out_corner_b <= stc[NB].b;
      result.out_corner_c <= stc[NB].c;
      result.normal_x     <= nrm[0];
      result.normal_y     <= nrm[1];
      result.normal_z     <= nrm[2];
      result.degenerate   <= std[NB];
    end
    if (rst) begin
      stv       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      stv       <= {stv[NB-1:0], in_valid};
      out_valid <= stv[NB];
    end
  end

endmodule

[design/triangle_face_normal.sv]
// Triangle face normal unit, top level. Instantiates tfn_front, tfn_queue,
// tfn_cross and tfn_norm; types and widths come from tfn_pkg.
//
// Load items write one vertex (signed Q16.16, low COORD_WIDTH bits kept) into
// a single-port vertex store and give no result. A triangle item reads its
// three corners from that store, one per cycle, and the single store port
// keeps intake closed while its second and third corner reads run. Loads can
// follow a triangle in the cycle its last read is done. Behind the store,
// edges go through a 4-entry queue into a fully pipelined back end: exact
// cross product and squares (5 stages), then a squared-length stage and a
// 15-stage normalizer that settles one bit of each Q2.14 component per stage
// by comparing q^2*|c|^2 with c_i^2*2^28, then the result register.
// A zero cross product returns a zero normal with degenerate set. Corners
// beyond VERTEX_DEPTH read as the origin; loads beyond it are dropped. The
// store has no reset: read only vertices written since reset. A stalled result
// holds the whole back end, and the queue then fills before intake stops.
module triangle_face_normal #(
  parameter int VERTEX_DEPTH = tfn_pkg::VERTEX_DEPTH_DEF,
  parameter int COORD_WIDTH  = tfn_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tfn_pkg::in_item_t  request,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output tfn_pkg::out_item_t result
);

  logic q_push, q_pop, q_empty;
  logic [tfn_pkg::QUEUE_LVL_W-1:0] q_level;
  tfn_pkg::edge_item_t q_wr_item, q_rd_item;

  logic adv;
  logic cr_valid;
  tfn_pkg::corners_t cr_corners;
  logic [2:0][tfn_pkg::SQ_W-1:0] cr_sq;
  logic [2:0] cr_neg;
  logic out_valid;

  // Advance the back end whenever the result register is free or being taken
  assign adv   = !out_valid || pop;
  // Drain the queue head, if any, into the first back stage on every advance
  assign q_pop = adv && !q_empty;
  assign empty = !out_valid;

  tfn_front #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .request (request),
    .full    (full),
    .q_level (q_level),
    .q_push  (q_push),
    .q_item  (q_wr_item)
  );

  tfn_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty),
    .level   (q_level)
  );

  tfn_cross u_cross (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (q_pop),
    .in_item     (q_rd_item),
    .out_valid   (cr_valid),
    .out_corners (cr_corners),
    .out_sq      (cr_sq),
    .out_neg     (cr_neg)
  );

  tfn_norm u_norm (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (cr_valid),
    .in_corners (cr_corners),
    .in_sq      (cr_sq),
    .in_neg     (cr_neg),
    .out_valid  (out_valid),
    .result     (result)
  );

endmodule

[verif/tb_top.sv]
// Testbench for triangle_face_normal: loads vertices, requests triangle normals
// and checks every result against an exact in-bench normal predictor.
// Depends on tfn_pkg and the triangle_face_normal RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tfn_pkg::*;

  localparam int RUN_LIMIT = 400000;   // cycles; far above the slowest clean run
  localparam int SETTLE    = 60;       // back-end latency plus margin

  logic      clk;
  logic      rst;
  logic      push;
  in_item_t  request;
  logic      full;
  logic      empty;
  logic      pop;
  out_item_t result;

  triangle_face_normal dut (
    .clk(clk), .rst(rst), .push(push), .request(request), .full(full),
    .empty(empty), .pop(pop), .result(result)
  );

  // Shadow of the vertex store; only written slots are ever read back.
  logic signed [COORD_IN_W-1:0] shadow_x [VERTEX_DEPTH_DEF];
  logic signed [COORD_IN_W-1:0] shadow_y [VERTEX_DEPTH_DEF];
  logic signed [COORD_IN_W-1:0] shadow_z [VERTEX_DEPTH_DEF];
  bit        slot_loaded [VERTEX_DEPTH_DEF];
  int        loaded_slots [$];
  out_item_t pending_normals [$];

  int mismatches;
  int cycles;
  int triangles_sent, loads_sent, normals_checked, flat_seen;
  int send_idle_pct, recv_idle_pct;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d normals outstanding", cycles,
               pending_normals.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input longint got,
                                 input longint want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  // Exact face normal of (B-A) x (C-A), truncated Q2.14 unit vector.
  function automatic out_item_t face_normal(input logic [INDEX_W-1:0] ia,
                                            input logic [INDEX_W-1:0] ib,
                                            input logic [INDEX_W-1:0] ic);
    out_item_t n;
    logic signed [71:0] e1 [3];
    logic signed [71:0] e2 [3];
    logic signed [71:0] cr [3];
    logic [71:0]  mag [3];
    logic [199:0] sq [3];
    logic [199:0] len2, goal, trial;
    logic [15:0]  q;
    n = '0;
    n.out_corner_a = ia;
    n.out_corner_b = ib;
    n.out_corner_c = ic;
    e1[0] = 72'(shadow_x[ib]) - 72'(shadow_x[ia]);
    e1[1] = 72'(shadow_y[ib]) - 72'(shadow_y[ia]);
    e1[2] = 72'(shadow_z[ib]) - 72'(shadow_z[ia]);
    e2[0] = 72'(shadow_x[ic]) - 72'(shadow_x[ia]);
    e2[1] = 72'(shadow_y[ic]) - 72'(shadow_y[ia]);
    e2[2] = 72'(shadow_z[ic]) - 72'(shadow_z[ia]);
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? 72'(-cr[i]) : 72'(cr[i]);
      sq[i]  = {128'b0, mag[i]} * {128'b0, mag[i]};
    end
    len2 = sq[0] + sq[1] + sq[2];
    if (len2 == 0) begin
      n.degenerate = 1'b1;
      return n;
    end
    for (int i = 0; i < 3; i++) begin
      goal = sq[i] << 28;
      q = '0;
      // settle one bit of the magnitude per pass, MSB first
      for (int b = 14; b >= 0; b--) begin
        trial = 200'(q | (16'd1 << b));
        if (trial * trial * len2 <= goal) q = q | (16'd1 << b);
      end
      if (cr[i] < 0) q = -q;
      case (i)
        0: n.normal_x = q;
        1: n.normal_y = q;
        default: n.normal_z = q;
      endcase
    end
    return n;
  endfunction

  // Drive one item at the falling edge, hold it until the block takes it,
  // then update the shadow store or queue the expected normal.
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      push = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    push    = 1'b1;
    request = it;
    do @(posedge clk); while (full);
    if (it.req_type == REQ_LOAD) begin
      loads_sent++;
      shadow_x[it.vertex_index] = it.coord_x;
      shadow_y[it.vertex_index] = it.coord_y;
      shadow_z[it.vertex_index] = it.coord_z;
      if (!slot_loaded[it.vertex_index]) loaded_slots.push_back(int'(it.vertex_index));
      slot_loaded[it.vertex_index] = 1'b1;
    end else begin
      triangles_sent++;
      pending_normals.push_back(face_normal(it.corner_a, it.corner_b, it.corner_c));
    end
  endtask

  task automatic release_push();
    @(negedge clk);
    push = 1'b0;
  endtask

  // Noise in the fields the block ignores for each kind of item.
  function automatic in_item_t noise_item();
    in_item_t it;
    it.req_type     = REQ_LOAD;
    it.vertex_index = INDEX_W'($urandom_range(1023));
    it.coord_x      = $urandom;
    it.coord_y      = $urandom;
    it.coord_z      = $urandom;
    it.corner_a     = INDEX_W'($urandom_range(1023));
    it.corner_b     = INDEX_W'($urandom_range(1023));
    it.corner_c     = INDEX_W'($urandom_range(1023));
    return it;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($signed($urandom_range(8191)) - 4096) <<< 12;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_vertex(input int slot, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
    in_item_t it;
    it = noise_item();
    it.req_type     = REQ_LOAD;
    it.vertex_index = INDEX_W'(slot);
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    send_item(it);
  endtask

  task automatic ask_triangle(input int a, input int b, input int c);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_TRIANGLE;
    it.corner_a = INDEX_W'(a);
    it.corner_b = INDEX_W'(b);
    it.corner_c = INDEX_W'(c);
    send_item(it);
  endtask

  task automatic random_triangle();
    int a, b, c;
    a = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
    b = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
    c = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
    // now and then repeat a corner for a flat triangle
    if ($urandom_range(9) == 0) c = a;
    ask_triangle(a, b, c);
  endtask

  task automatic random_item();
    if (loaded_slots.size() < 3 || $urandom_range(99) < 35)
      load_vertex($urandom_range(1023), pick_coord(), pick_coord(), pick_coord());
    else
      random_triangle();
  endtask

  // Wait until every expected normal has come back.
  task automatic drain();
    release_push();
    wait (pending_normals.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver: decide pop at the falling edge, check at the rising edge.
  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_normals.size() == 0) begin
        report_mismatch("unexpected result, out_corner_a", result.out_corner_a, -1);
      end else begin
        want = pending_normals.pop_front();
        normals_checked++;
        if (want.degenerate) flat_seen++;
        if (result.out_corner_a !== want.out_corner_a)
          report_mismatch("out_corner_a", result.out_corner_a, want.out_corner_a);
        if (result.out_corner_b !== want.out_corner_b)
          report_mismatch("out_corner_b", result.out_corner_b, want.out_corner_b);
        if (result.out_corner_c !== want.out_corner_c)
          report_mismatch("out_corner_c", result.out_corner_c, want.out_corner_c);
        if (result.normal_x !== want.normal_x)
          report_mismatch("normal_x", result.normal_x, want.normal_x);
        if (result.normal_y !== want.normal_y)
          report_mismatch("normal_y", result.normal_y, want.normal_y);
        if (result.normal_z !== want.normal_z)
          report_mismatch("normal_z", result.normal_z, want.normal_z);
        if (result.degenerate !== want.degenerate)
          report_mismatch("degenerate", result.degenerate, want.degenerate);
      end
    end
  end

  // Unit axes, both windings, and coordinate extremes.
  task automatic test_axes_and_extremes();
    load_vertex(0, 32'h0, 32'h0, 32'h0);
    load_vertex(1, 32'h0001_0000, 32'h0, 32'h0);
    load_vertex(2, 32'h0, 32'h0001_0000, 32'h0);
    load_vertex(5, 32'h0, 32'h0, 32'h0001_0000);
    ask_triangle(0, 1, 2);
    ask_triangle(0, 2, 1);
    ask_triangle(0, 2, 5);
    ask_triangle(0, 5, 1);
    load_vertex(1023, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    load_vertex(512, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    load_vertex(3, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    load_vertex(6, 32'h8000_0000, 32'h0, 32'h7fff_ffff);
    ask_triangle(1023, 3, 6);
    ask_triangle(512, 6, 3);
    ask_triangle(3, 1023, 6);
    drain();
  endtask

  // Repeated corners and collinear points give a zero normal.
  task automatic test_flat_triangles();
    load_vertex(4, 32'h0002_0000, 32'h0, 32'h0);
    ask_triangle(1, 1, 1);
    ask_triangle(0, 1, 4);
    ask_triangle(1023, 512, 0);
    ask_triangle(3, 3, 6);
    drain();
  endtask

  task automatic test_random_mix(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) random_item();
    drain();
  endtask

  // Hold the receiver off long enough for the queue to back up into intake.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk);
    hold_left = 400;
    repeat (40) random_triangle();
    drain();
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    request = '0;
    cycles = 0;
    mismatches = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_axes_and_extremes();
    test_flat_triangles();
    test_random_mix(240, 6, 61);
    test_random_mix(240, 61, 6);
    test_random_mix(240, 0, 0);
    test_backpressure();

    $display("covered %0d loads and %0d triangles; %0d normals checked, %0d flat",
             loads_sent, triangles_sent, normals_checked, flat_seen);
    $display("idling on either side, a long result stall and full drains included");
    if (mismatches == 0 && pending_normals.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
